@@ rtl/cteb_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the cursor text edit buffer.
package cteb_pkg;

  localparam int ADDR_W       = 12;
  localparam int BUFFER_DEPTH = 1 << ADDR_W;
  localparam int LEN_W        = ADDR_W + 1;
  localparam int CNT_W        = 16;
  localparam int CHAR_W       = 8;
  localparam int OP_W         = 3;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_LEFT   = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_BACK   = 3'd3,
    OP_INSERT = 3'd4,
    OP_DELETE = 3'd5,
    OP_READ   = 3'd6
  } cteb_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_PREP,
    ST_DEL_PREP,
    ST_MOVE,
    ST_PUT,
    ST_RD_WAIT
  } cteb_state_t;

  // Block move request: copy count bytes, src to dst, stepping up or down.
  typedef struct packed {
    logic              start;
    logic              up;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    logic [LEN_W-1:0]  count;
  } cteb_mv_cmd_t;

  // Mover status and its memory port requests.
  typedef struct packed {
    logic              active;
    logic              done;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
  } cteb_mv_stat_t;

endpackage

@@ rtl/cteb_store.sv @@
`timescale 1ns / 1ps
// Character store: one write port, one registered read port.
module cteb_store
  import cteb_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cteb_mover.sv @@
`timescale 1ns / 1ps
// Block mover: shifts a run of stored bytes one address per cycle.
module cteb_mover
  import cteb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cteb_mv_cmd_t  cmd,
  output cteb_mv_stat_t stat
);

  logic              active;
  logic              up;
  logic              pend;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] dst;
  logic [ADDR_W-1:0] pend_dst;
  logic [LEN_W-1:0]  remaining;
  logic              done;

  assign done = active && (remaining == '0) && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pend   <= 1'b0;
    end else if (cmd.start) begin
      active    <= 1'b1;
      up        <= cmd.up;
      src       <= cmd.src;
      dst       <= cmd.dst;
      remaining <= cmd.count;
      pend      <= 1'b0;
    end else if (active) begin
      if (remaining != '0) begin
        // read issued at src now; data lands next cycle for pend_dst
        src       <= up ? src + ADDR_W'(1) : src - ADDR_W'(1);
        dst       <= up ? dst + ADDR_W'(1) : dst - ADDR_W'(1);
        remaining <= remaining - LEN_W'(1);
        pend      <= 1'b1;
        pend_dst  <= dst;
      end else begin
        pend <= 1'b0;
      end
      if (done) begin
        active <= 1'b0;
      end
    end
  end

  assign stat.active  = active;
  assign stat.done    = done;
  assign stat.wr_en   = pend;
  assign stat.wr_addr = pend_dst;
  assign stat.rd_addr = src;

  cmd_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !active)
    else $error("mover restarted while active");

  write_follows_read: assert property (@(posedge clk) disable iff (rst)
    (active && !cmd.start && remaining != '0) |=> pend)
    else $error("mover read not followed by write");

  done_ends_run: assert property (@(posedge clk) disable iff (rst)
    (done && !cmd.start) |=> !active)
    else $error("mover still active after done");

endmodule

@@ rtl/cursor_text_edit_buffer.sv @@
`timescale 1ns / 1ps
// Top level of the cursor text edit buffer: command decode, state, sequencer.
//
// A 4096-byte text store with a cursor. A transaction is taken at a clock edge
// with start high and busy low; exactly one result comes back per transaction,
// marked by a one-cycle done strobe that the receiver cannot hold off, and
// the result ports keep their values until the next result. Timing:
//   load_char, left, right, unused code, out-of-range read_char, and any
//     dropped or empty edit: done in the cycle after start, busy never rises.
//   read_char in range: a registered store read in ST_RD_WAIT, then done.
//   backspace runs ST_MOVE, delete_after ST_DEL_PREP and ST_MOVE,
//     insert_char ST_INS_PREP, ST_MOVE and ST_PUT, each then done. The
//     time in ST_MOVE grows with k, the number of stored characters that
//     have to slide by the edit (text after the edit point). The store has
//     one read and one write port and the mover walks it one byte per
//     cycle, so k sets the cost, highest at the front of a full buffer.
// The store needs no clearing pass after reset; only bytes below the length
// are ever read back. An insert or load into a full buffer is dropped and
// reported through overflow.
module cursor_text_edit_buffer
  import cteb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [CHAR_W-1:0] character,
  input  logic              word_start,
  input  logic [CNT_W-1:0]  count,
  input  logic [ADDR_W-1:0] read_index,
  output logic              done,
  output logic [LEN_W-1:0]  text_length,
  output logic [LEN_W-1:0]  cursor_position,
  output logic [CHAR_W-1:0] read_data,
  output logic              read_valid,
  output logic              overflow
);

  cteb_state_t state, state_next;

  // architectural state
  logic [LEN_W-1:0]  text_len, len_next;
  logic [LEN_W-1:0]  cursor, cursor_next;
  logic [LEN_W-1:0]  ins_offset, offset_next;

  // per-transaction holding registers
  logic [LEN_W-1:0]  ins_pos, ins_pos_next;
  logic [LEN_W-1:0]  del_n, del_n_next;
  logic [CHAR_W-1:0] char_r, char_next;
  logic              is_ins, is_ins_next;

  // result staging
  logic              finish;
  logic              fin_rvalid;
  logic [CHAR_W-1:0] fin_rdata;
  logic              fin_ovf;

  // store ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  cteb_mv_cmd_t  mv_cmd;
  cteb_mv_stat_t mv_stat;

  // edit-point arithmetic
  logic [LEN_W-1:0]  off_base;
  logic [LEN_W-1:0]  off_sat;
  logic [LEN_W:0]    ins_sum;
  logic [LEN_W-1:0]  ins_clamped;
  logic [LEN_W-1:0]  room;
  logic [LEN_W-1:0]  del_want;
  logic [LEN_W-1:0]  cur_plus_n;
  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  cursor_m1;

  assign off_base    = word_start ? '0 : ins_offset;
  assign off_sat     = (off_base < DEPTH_LEN) ? off_base + LEN_W'(1) : off_base;
  assign ins_sum     = {1'b0, cursor} + {1'b0, off_base};
  // insert past the end lands at the end
  assign ins_clamped = (ins_sum > {1'b0, text_len}) ? text_len : ins_sum[LEN_W-1:0];
  assign room        = text_len - cursor;
  assign del_want    = (count < CNT_W'(room)) ? count[LEN_W-1:0] : room;
  assign cur_plus_n  = cursor + del_n;
  assign len_m1      = text_len - LEN_W'(1);
  assign cursor_m1   = cursor - LEN_W'(1);

  assign busy = (state != ST_IDLE);

  cteb_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cteb_mover u_mover (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mv_cmd),
    .stat (mv_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      text_len   <= '0;
      cursor     <= '0;
      ins_offset <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      text_len   <= len_next;
      cursor     <= cursor_next;
      ins_offset <= offset_next;
      done       <= finish;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ins_pos <= ins_pos_next;
    del_n   <= del_n_next;
    char_r  <= char_next;
    is_ins  <= is_ins_next;
    if (finish) begin
      text_length     <= len_next;
      cursor_position <= cursor_next;
      read_data       <= fin_rdata;
      read_valid      <= fin_rvalid;
      overflow        <= fin_ovf;
    end
  end

  always_comb begin
    state_next   = state;
    len_next     = text_len;
    cursor_next  = cursor;
    offset_next  = ins_offset;
    ins_pos_next = ins_pos;
    del_n_next   = del_n;
    char_next    = char_r;
    is_ins_next  = is_ins;
    finish       = 1'b0;
    fin_rvalid   = 1'b0;
    fin_rdata    = '0;
    fin_ovf      = 1'b0;
    mv_cmd       = '0;
    // mover owns the store while it runs
    mem_we       = mv_stat.wr_en;
    mem_waddr    = mv_stat.wr_addr;
    mem_wdata    = mem_rdata;
    mem_raddr    = mv_stat.rd_addr;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (operation)
            OP_LOAD: begin
              if (text_len < DEPTH_LEN) begin
                mem_we      = 1'b1;
                mem_waddr   = text_len[ADDR_W-1:0];
                mem_wdata   = character;
                len_next    = text_len + LEN_W'(1);
                cursor_next = text_len + LEN_W'(1);
              end else begin
                fin_ovf = 1'b1;
              end
              finish = 1'b1;
            end
            OP_LEFT: begin
              if (cursor != '0) begin
                cursor_next = cursor_m1;
              end
              finish = 1'b1;
            end
            OP_RIGHT: begin
              if (cursor < text_len) begin
                cursor_next = cursor + LEN_W'(1);
              end
              finish = 1'b1;
            end
            OP_BACK: begin
              if (cursor != '0) begin
                // slide text after the cursor down by one
                mv_cmd.start = 1'b1;
                mv_cmd.up    = 1'b1;
                mv_cmd.dst   = cursor_m1[ADDR_W-1:0];
                mv_cmd.src   = cursor[ADDR_W-1:0];
                mv_cmd.count = room;
                len_next     = len_m1;
                cursor_next  = cursor_m1;
                is_ins_next  = 1'b0;
                state_next   = ST_MOVE;
              end else begin
                finish = 1'b1;
              end
            end
            OP_INSERT: begin
              offset_next = off_base;
              if (text_len < DEPTH_LEN) begin
                offset_next  = off_sat;
                ins_pos_next = ins_clamped;
                char_next    = character;
                is_ins_next  = 1'b1;
                state_next   = ST_INS_PREP;
              end else begin
                fin_ovf = 1'b1;
                finish  = 1'b1;
              end
            end
            OP_DELETE: begin
              if (del_want != '0) begin
                del_n_next  = del_want;
                is_ins_next = 1'b0;
                state_next  = ST_DEL_PREP;
              end else begin
                finish = 1'b1;
              end
            end
            OP_READ: begin
              if (LEN_W'(read_index) < text_len) begin
                mem_raddr  = read_index;
                state_next = ST_RD_WAIT;
              end else begin
                finish = 1'b1;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_INS_PREP: begin
        // open a hole at ins_pos: slide the tail up by one, top first
        mv_cmd.start = 1'b1;
        mv_cmd.up    = 1'b0;
        mv_cmd.dst   = text_len[ADDR_W-1:0];
        mv_cmd.src   = len_m1[ADDR_W-1:0];
        mv_cmd.count = text_len - ins_pos;
        state_next   = ST_MOVE;
      end
      ST_DEL_PREP: begin
        mv_cmd.start = 1'b1;
        mv_cmd.up    = 1'b1;
        mv_cmd.dst   = cursor[ADDR_W-1:0];
        mv_cmd.src   = cur_plus_n[ADDR_W-1:0];
        mv_cmd.count = room - del_n;
        len_next     = text_len - del_n;
        state_next   = ST_MOVE;
      end
      ST_MOVE: begin
        if (mv_stat.done) begin
          if (is_ins) begin
            state_next = ST_PUT;
          end else begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = ins_pos[ADDR_W-1:0];
        mem_wdata  = char_r;
        len_next   = text_len + LEN_W'(1);
        finish     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_WAIT: begin
        fin_rvalid = 1'b1;
        fin_rdata  = mem_rdata;
        finish     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    cursor <= text_len)
    else $error("cursor beyond end of text");

  length_in_range: assert property (@(posedge clk) disable iff (rst)
    (text_len <= DEPTH_LEN) && (ins_offset <= DEPTH_LEN))
    else $error("length or insert offset out of range");

  mover_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mv_stat.active)
    else $error("mover running with sequencer idle");

  done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transaction");

  one_result_per_busy_run: assert property (@(posedge clk) disable iff (rst)
    (busy && !finish) |=> !done)
    else $error("result strobe while transaction still in progress");

endmodule

@@ dv/cursor_text_edit_buffer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the cursor text edit buffer.
module cursor_text_edit_buffer_tb;
  import cteb_pkg::*;

  localparam int CLK_PERIOD   = 20;
  // The run is mostly short texts, a fill to a full store, and a few
  // edits that slide the whole store.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1950;
  // Keep the random text short so that each edit slides only a few bytes.
  localparam int TEXT_CAP     = 48;
  localparam int DRAIN_CYCLES = 16;
  // Code 7 is not decoded: the transaction only reports the state.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [ADDR_W-1:0] IDX_MAX = '1;

  typedef struct {
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  cur;
    logic [CHAR_W-1:0] data;
    logic              rvalid;
    logic              ovf;
  } edit_result_t;

  // Tracks the text and cursor, predicts one result per accepted
  // transaction and checks the results in order.
  class edit_scoreboard;
    logic [CHAR_W-1:0] text_mem [BUFFER_DEPTH];
    int text_len;
    int cursor;
    int ins_offset;
    int errors;
    edit_result_t pending_q[$];

    function new();
      text_len   = 0;
      cursor     = 0;
      ins_offset = 0;
      errors     = 0;
    endfunction

    // Close the hole of n bytes at pos.
    function void remove_span(int pos, int n);
      for (int i = pos; i + n < text_len; i++) text_mem[i] = text_mem[i + n];
      text_len -= n;
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                               logic ws, logic [CNT_W-1:0] cnt,
                               logic [ADDR_W-1:0] idx);
      edit_result_t r;
      int pos;
      int n;
      r.data   = '0;
      r.rvalid = 1'b0;
      r.ovf    = 1'b0;
      case (op)
        OP_LOAD: begin
          if (text_len < BUFFER_DEPTH) begin
            text_mem[text_len] = ch;
            text_len++;
            cursor = text_len;
          end else begin
            r.ovf = 1'b1;
          end
        end
        OP_LEFT: begin
          if (cursor > 0) cursor--;
        end
        OP_RIGHT: begin
          if (cursor < text_len) cursor++;
        end
        OP_BACK: begin
          if (cursor > 0) begin
            remove_span(cursor - 1, 1);
            cursor--;
          end
        end
        OP_INSERT: begin
          // word start clears the offset even when the insert is dropped
          if (ws) ins_offset = 0;
          if (text_len < BUFFER_DEPTH) begin
            pos = cursor + ins_offset;
            if (pos > text_len) pos = text_len;
            for (int i = text_len; i > pos; i--) text_mem[i] = text_mem[i - 1];
            text_mem[pos] = ch;
            text_len++;
            if (ins_offset < BUFFER_DEPTH) ins_offset++;
          end else begin
            r.ovf = 1'b1;
          end
        end
        OP_DELETE: begin
          n = text_len - cursor;
          if (int'(cnt) < n) n = int'(cnt);
          if (n > 0) remove_span(cursor, n);
        end
        OP_READ: begin
          if (int'(idx) < text_len) begin
            r.data   = text_mem[idx];
            r.rvalid = 1'b1;
          end
        end
        default: begin
        end
      endcase
      r.len = LEN_W'(text_len);
      r.cur = LEN_W'(cursor);
      pending_q.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(edit_result_t got);
      edit_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none, actual len %0d",
                 $time, got.len);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("text_length", want.len, got.len);
      compare_field("cursor_position", want.cur, got.cur);
      compare_field("read_data", want.data, got.data);
      compare_field("read_valid", want.rvalid, got.rvalid);
      compare_field("overflow", want.ovf, got.ovf);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] character;
  logic              word_start;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] read_index;
  logic              done;
  logic [LEN_W-1:0]  text_length;
  logic [LEN_W-1:0]  cursor_position;
  logic [CHAR_W-1:0] read_data;
  logic              read_valid;
  logic              overflow;

  edit_scoreboard sb = new();
  edit_result_t   observed;
  int             items_sent = 0;
  bit             quiet = 1'b0;

  cursor_text_edit_buffer dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .character      (character),
    .word_start     (word_start),
    .count          (count),
    .read_index     (read_index),
    .done           (done),
    .text_length    (text_length),
    .cursor_position(cursor_position),
    .read_data      (read_data),
    .read_valid     (read_valid),
    .overflow       (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Result monitor: done marks a one-cycle result, sampled at the edge that
  // ends it. The receiver has no way to stall.
  always @(posedge clk) begin
    if (!rst && done) begin
      observed.len    = text_length;
      observed.cur    = cursor_position;
      observed.data   = read_data;
      observed.rvalid = read_valid;
      observed.ovf    = overflow;
      sb.check_result(observed);
    end
  end

  // One transaction: optional idle gap, then hold start until an edge with
  // busy low takes it. Called and returns at a falling edge. start stays
  // high into the next call when that call draws no gap.
  task automatic issue_command(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                               input logic ws, input logic [CNT_W-1:0] cnt,
                               input logic [ADDR_W-1:0] idx);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation  = op;
    character  = ch;
    word_start = ws;
    count      = cnt;
    read_index = idx;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(op, ch, ws, cnt, idx);
    @(negedge clk);
    items_sent++;
    // every 64 transactions, maybe switch to a burst with no idle cycles
    if (items_sent % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly small counts, now and then any 16-bit value.
  function automatic logic [CNT_W-1:0] rand_count();
    if ($urandom_range(0, 7) == 0) return CNT_W'($urandom);
    return CNT_W'($urandom_range(0, 6));
  endfunction

  // Mostly near the text, now and then anywhere in the index range.
  function automatic logic [ADDR_W-1:0] rand_index();
    if ($urandom_range(0, 7) == 0) return ADDR_W'($urandom);
    return ADDR_W'($urandom_range(0, sb.text_len + 2));
  endfunction

  initial begin
    int burst;
    int pick;
    bit broken;
    logic [OP_W-1:0] op;

    rst        = 1'b1;
    start      = 1'b0;
    operation  = OP_LOAD;
    character  = '0;
    word_start = 1'b0;
    count      = '0;
    read_index = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed: empty-buffer corner cases ---
    issue_command(OP_READ, 8'h00, 1'b0, '0, '0);         // read past end
    issue_command(OP_LEFT, 8'h00, 1'b0, '0, '0);         // clamp at start
    issue_command(OP_RIGHT, 8'h00, 1'b0, '0, '0);        // clamp at end
    issue_command(OP_BACK, 8'h00, 1'b0, '0, '0);         // nothing before cursor
    issue_command(OP_DELETE, 8'h00, 1'b0, CNT_MAX, '0);  // nothing after cursor
    issue_command(OP_UNUSED, 8'hFF, 1'b1, CNT_MAX, IDX_MAX);
    // character extremes and letters
    issue_command(OP_LOAD, 8'h00, 1'b0, '0, '0);
    issue_command(OP_LOAD, 8'hFF, 1'b1, CNT_MAX, IDX_MAX);
    issue_command(OP_LOAD, "L", 1'b0, '0, '0);
    issue_command(OP_LOAD, "R", 1'b0, '0, '0);
    issue_command(OP_READ, 8'h00, 1'b0, '0, 12'd1);
    issue_command(OP_READ, 8'h00, 1'b0, '0, 12'd4);      // index == length
    issue_command(OP_READ, 8'h00, 1'b0, '0, IDX_MAX);
    // word insert in the middle, cursor stays put
    issue_command(OP_LEFT, 8'h00, 1'b0, '0, '0);
    issue_command(OP_LEFT, 8'h00, 1'b0, '0, '0);
    issue_command(OP_INSERT, "B", 1'b1, '0, '0);
    issue_command(OP_INSERT, "I", 1'b0, '0, '0);
    issue_command(OP_INSERT, 8'hA5, 1'b0, '0, '0);
    // shrink the text so the running offset points past the end
    issue_command(OP_DELETE, 8'h00, 1'b0, 16'd3, '0);
    issue_command(OP_INSERT, 8'h5A, 1'b0, '0, '0);
    issue_command(OP_BACK, 8'h00, 1'b0, '0, '0);
    issue_command(OP_DELETE, 8'h00, 1'b0, '0, '0);       // zero count
    issue_command(OP_DELETE, 8'h00, 1'b0, CNT_MAX, '0);  // clamped to the end
    issue_command(OP_READ, 8'h00, 1'b0, '0, '0);

    // --- random: word bursts of inserts mixed with single edits ---
    while (items_sent < 24 + RANDOM_ITEMS) begin
      if (sb.text_len >= TEXT_CAP) begin
        // trim: backspace when possible, else delete from the front
        if (sb.cursor > 0) issue_command(OP_BACK, CHAR_W'($urandom), 1'($urandom),
                                         rand_count(), rand_index());
        else issue_command(OP_DELETE, CHAR_W'($urandom), 1'($urandom), 16'd16,
                           rand_index());
      end else if ($urandom_range(0, 9) < 4) begin
        burst  = $urandom_range(1, 8);
        // a broken word carries no start flag on its first character
        broken = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < burst; k++) begin
          issue_command(OP_INSERT, CHAR_W'($urandom), (k == 0) && !broken, rand_count(),
                        rand_index());
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15)      op = OP_LOAD;
        else if (pick < 30) op = OP_LEFT;
        else if (pick < 45) op = OP_RIGHT;
        else if (pick < 58) op = OP_BACK;
        else if (pick < 68) op = OP_INSERT;
        else if (pick < 80) op = OP_DELETE;
        else if (pick < 97) op = OP_READ;
        else                op = OP_UNUSED;
        issue_command(op, CHAR_W'($urandom), 1'($urandom), rand_count(), rand_index());
      end
    end

    // --- fill the store: a load puts the cursor at the end, then one long
    // word appends at cursor + offset, which also runs the offset up ---
    issue_command(OP_LOAD, CHAR_W'($urandom), 1'b0, '0, '0);
    issue_command(OP_INSERT, CHAR_W'($urandom), 1'b1, '0, '0);
    while (sb.text_len < BUFFER_DEPTH) begin
      if ($urandom_range(0, 15) == 0)
        issue_command(OP_READ, 8'h00, 1'b0, '0, rand_index());
      else
        issue_command(OP_INSERT, CHAR_W'($urandom), 1'b0, rand_count(), '0);
    end

    // --- full store: drops flag overflow, then a few whole-store slides ---
    issue_command(OP_LOAD, 8'hFF, 1'b0, '0, '0);
    issue_command(OP_INSERT, 8'h00, 1'b1, '0, '0);
    issue_command(OP_INSERT, 8'hFF, 1'b0, '0, '0);
    issue_command(OP_READ, 8'h00, 1'b0, '0, IDX_MAX);
    issue_command(OP_READ, 8'h00, 1'b0, '0, '0);
    issue_command(OP_BACK, 8'h00, 1'b0, '0, '0);
    issue_command(OP_INSERT, "I", 1'b1, '0, '0);
    issue_command(OP_LOAD, "L", 1'b0, '0, '0);
    issue_command(OP_RIGHT, 8'h00, 1'b0, '0, '0);
    issue_command(OP_RIGHT, 8'h00, 1'b0, '0, '0);
    issue_command(OP_DELETE, 8'h00, 1'b0, CNT_MAX, '0);
    issue_command(OP_READ, 8'h00, 1'b0, '0, IDX_MAX);
    issue_command(OP_LEFT, 8'h00, 1'b0, '0, '0);
    issue_command(OP_DELETE, 8'h00, 1'b0, '0, '0);
    issue_command(OP_READ, 8'h00, 1'b0, '0, rand_index());
    start = 1'b0;

    // drain, then a short quiet window to catch stray results
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cteb_pkg.sv
rtl/cteb_store.sv
rtl/cteb_mover.sv
rtl/cursor_text_edit_buffer.sv
dv/cursor_text_edit_buffer_tb.sv
